/* src/cil_pkg.sv */
// ----------------------------------------------------------------------------
// cil_pkg
// shared types, codes and defaults for the compacting indexed list
// ----------------------------------------------------------------------------
package cil_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int WORD_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [VALUE_W-1:0] read_word;
        logic [COUNT_W-1:0] item_count;
    } rsp_t;

    typedef struct packed {
        logic load_tail;
        logic write_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

/* src/cil_cell.sv */
// ----------------------------------------------------------------------------
// cil_cell
// one list slot: loads on append or write, takes its upper neighbor on remove
// ----------------------------------------------------------------------------
module cil_cell #(
    parameter int LIST_DEPTH = cil_pkg::LIST_DEPTH,
    parameter int WORD_WIDTH = cil_pkg::WORD_WIDTH,
    parameter int POS        = 0
) (
    input  logic                                     clk,
    input  cil_pkg::cell_ctrl_t                      ctrl,
    input  logic [cil_pkg::INDEX_W-1:0]              index,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]          count,
    input  logic [WORD_WIDTH-1:0]                    value,
    input  logic [WORD_WIDTH-1:0]                    upper_word,
    output logic [WORD_WIDTH-1:0]                    word,
    output logic [WORD_WIDTH-1:0]                    hit_word
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > cil_pkg::INDEX_W) ? CNT_W : cil_pkg::INDEX_W;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  at_tail;
    logic                  at_index;
    logic                  past_index;

    assign at_tail    = (count == CNT_W'(POS));
    assign at_index   = (CMP_W'(index) == CMP_W'(POS));
    assign past_index = (CMP_W'(index) <= CMP_W'(POS));

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load_tail && at_tail)
        begin
            word_next = value;
        end
        else if (ctrl.write_en && at_index)
        begin
            word_next = value;
        end
        else if (ctrl.shift_en && past_index)
        begin
            word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign hit_word = at_index ? word_reg : '0;

endmodule

/* src/compacting_indexed_list.sv */
// ----------------------------------------------------------------------------
// compacting_indexed_list_core
// bounded ordered word list built as a row of slot cells
// ----------------------------------------------------------------------------
// the result beat is registered and shows in the cycle after the request beat is taken
// throughput: one request per cycle; a remove shifts the cells from the index up at once
// busy stays low, so a request may be given in every cycle
// the receiver cannot stall; done is high for exactly one cycle per request
// reset clears the count and the result strobe; slot contents are not reset
module compacting_indexed_list_core #(
    parameter int LIST_DEPTH = cil_pkg::LIST_DEPTH,
    parameter int WORD_WIDTH = cil_pkg::WORD_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cil_pkg::req_t request,
    output logic          done,
    output cil_pkg::rsp_t result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > cil_pkg::INDEX_W) ? CNT_W : cil_pkg::INDEX_W;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    cil_pkg::rsp_t         result_reg;
    cil_pkg::rsp_t         result_next;
    cil_pkg::cell_ctrl_t   ctrl;
    logic                  accept;
    logic                  in_range;
    logic                  full;
    logic                  ok;
    logic [WORD_WIDTH-1:0] value;
    logic [WORD_WIDTH-1:0] sel_word;
    logic [WORD_WIDTH-1:0] words [LIST_DEPTH];
    logic [WORD_WIDTH-1:0] hits  [LIST_DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign value    = WORD_WIDTH'(request.entry_value);
    assign in_range = (CMP_W'(request.entry_index) < CMP_W'(count_reg));
    assign full     = (count_reg == CNT_W'(LIST_DEPTH));

    always_comb
    begin
        ctrl.load_tail = accept && (request.command == cil_pkg::CMD_APPEND) && !full;
        ctrl.write_en  = accept && (request.command == cil_pkg::CMD_WRITE) && in_range;
        ctrl.shift_en  = accept && (request.command == cil_pkg::CMD_REMOVE) && in_range;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] upper;
            if (gi == LIST_DEPTH - 1)
            begin : g_last
                assign upper = words[gi];
            end
            else
            begin : g_mid
                assign upper = words[gi+1];
            end

            cil_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .WORD_WIDTH (WORD_WIDTH),
                .POS        (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .index      (request.entry_index),
                .count      (count_reg),
                .value      (value),
                .upper_word (upper),
                .word       (words[gi]),
                .hit_word   (hits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        sel_word = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            sel_word = sel_word | hits[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ok         = 1'b0;
        result_next.read_word = '0;
        case (request.command)
            cil_pkg::CMD_APPEND:
            begin
                ok = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cil_pkg::CMD_READ:
            begin
                ok = in_range;
                if (in_range)
                begin
                    result_next.read_word = cil_pkg::VALUE_W'(sel_word);
                end
            end
            cil_pkg::CMD_WRITE:
            begin
                ok = in_range;
            end
            cil_pkg::CMD_REMOVE:
            begin
                ok = in_range;
                if (in_range)
                begin
                    result_next.read_word = cil_pkg::VALUE_W'(sel_word);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            cil_pkg::CMD_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        result_next.success    = ok;
        result_next.item_count = cil_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/cil_checker.sv */
// ----------------------------------------------------------------------------
// cil_checker
// port-level checks of request/result timing and result contents
// ----------------------------------------------------------------------------
module cil_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input cil_pkg::req_t request,
    input logic          done,
    input cil_pkg::rsp_t result
);

    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted request got no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without a request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.success |-> result.read_word == '0)
        else $error("failed request returned a nonzero word");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(request.command == cil_pkg::CMD_CLEAR)
            |-> result.success && result.item_count == '0)
        else $error("clear did not empty the list");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) && result.success
            && $past(request.command == cil_pkg::CMD_APPEND)
            |-> result.item_count
                == cil_pkg::COUNT_W'($past(result.item_count) + cil_pkg::COUNT_W'(1)))
        else $error("append did not advance the count by one");

endmodule

bind compacting_indexed_list_core cil_checker u_cil_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for compacting_indexed_list_core: a directed table covers reset,
// bad index, full list, clear, unused commands and the index extremes, then
// random requests biased toward valid indexes run under several sender idle
// mixes; each beat is checked against its table row or an in-bench list predictor
// ----------------------------------------------------------------------------
module tb_top;

    import cil_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 325;

    typedef struct {
        req_t        req;
        int unsigned reps;
        bit          typed;
        rsp_t        want;
    } step_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    logic [VALUE_W-1:0] list_words [LIST_DEPTH];
    int unsigned        list_count;
    rsp_t               pending_results [$];
    step_row_t          step_rows [$];
    int unsigned        mismatch_count;

    compacting_indexed_list_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    function automatic rsp_t apply_list_request(req_t r);
        rsp_t        o;
        int unsigned k;
        bit          hit;
        o   = '0;
        hit = r.entry_index < list_count;
        case (r.command)
            CMD_APPEND:
                if (list_count < LIST_DEPTH)
                begin
                    list_words[list_count] = r.entry_value;
                    list_count++;
                    o.success = 1'b1;
                end
            CMD_READ:
                if (hit)
                begin
                    o.read_word = list_words[r.entry_index];
                    o.success   = 1'b1;
                end
            CMD_WRITE:
                if (hit)
                begin
                    list_words[r.entry_index] = r.entry_value;
                    o.success = 1'b1;
                end
            CMD_REMOVE:
                if (hit)
                begin
                    o.read_word = list_words[r.entry_index];
                    for (k = r.entry_index + 1; k < list_count; k++)
                        list_words[k-1] = list_words[k];
                    list_count--;
                    o.success = 1'b1;
                end
            CMD_CLEAR:
            begin
                list_count = 0;
                o.success  = 1'b1;
            end
            default:
            begin
            end
        endcase
        o.item_count = list_count[COUNT_W-1:0];
        return o;
    endfunction

    function automatic req_t pick_list_request();
        req_t        r;
        int unsigned roll;
        roll          = $urandom_range(99);
        r.entry_value = $urandom;
        if (roll < 35)
            r.command = CMD_APPEND;
        else if (roll < 57)
            r.command = CMD_READ;
        else if (roll < 72)
            r.command = CMD_WRITE;
        else if (roll < 92)
            r.command = CMD_REMOVE;
        else if (roll < 95)
            r.command = CMD_CLEAR;
        else
            r.command = CMD_W'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
        if (list_count > 0 && $urandom_range(99) < 85)
            r.entry_index = INDEX_W'($urandom_range(list_count - 1));
        else
            r.entry_index = INDEX_W'($urandom);
        return r;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, int unsigned idx,
                                    logic [VALUE_W-1:0] val, int unsigned reps,
                                    bit typed, rsp_t want);
        step_row_t row;
        row.req.command     = cmd;
        row.req.entry_index = INDEX_W'(idx);
        row.req.entry_value = val;
        row.reps            = reps;
        row.typed           = typed;
        row.want            = want;
        step_rows.push_back(row);
    endfunction

    function automatic void flag_mismatch(string what, rsp_t want, rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected ok=%0b word=%h count=%0d, got ok=%0b word=%h count=%0d",
                     what, want.success, want.read_word, want.item_count,
                     got.success, got.read_word, got.item_count);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic issue(req_t r, bit typed, rsp_t want);
        rsp_t guess;
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        guess = apply_list_request(r);
        pending_results.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected beat", '0, result);
            else
            begin
                want = pending_results.pop_front();
                if (result.success !== want.success
                        || result.read_word !== want.read_word
                        || result.item_count !== want.item_count)
                    flag_mismatch("field", want, result);
            end
        end
    end

    initial
    begin : stimulus
        step_row_t   row;
        req_t        r;
        int unsigned rep;
        int unsigned n;
        int unsigned idle_pct [RANDOM_PHASES];
        idle_pct   = '{0, 50, 29, 0};
        list_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list after reset
        add_row(CMD_READ,   0,  32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        add_row(CMD_REMOVE, 15, 32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        add_row(CMD_WRITE,  15, 32'hFFFFFFFF, 1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        add_row(CMD_CLEAR,  0,  32'h0,        1, 1, rsp_t'{1'b1, 32'h0, 5'd0});
        add_row(CMD_RSVD_A, 0,  32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        add_row(CMD_RSVD_B, 7,  32'h12345678, 1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        add_row(CMD_RSVD_C, 15, 32'hFFFFFFFF, 1, 1, rsp_t'{1'b0, 32'h0, 5'd0});
        // small list
        add_row(CMD_APPEND, 0,  32'hFFFFFFFF, 1, 1, rsp_t'{1'b1, 32'h0, 5'd1});
        add_row(CMD_APPEND, 15, 32'h0,        1, 1, rsp_t'{1'b1, 32'h0, 5'd2});
        add_row(CMD_READ,   0,  32'h0,        1, 1, rsp_t'{1'b1, 32'hFFFFFFFF, 5'd2});
        add_row(CMD_READ,   2,  32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd2});
        add_row(CMD_WRITE,  1,  32'hA5A5A5A5, 1, 1, rsp_t'{1'b1, 32'h0, 5'd2});
        add_row(CMD_REMOVE, 0,  32'h0,        1, 1, rsp_t'{1'b1, 32'hFFFFFFFF, 5'd1});
        add_row(CMD_READ,   0,  32'h0,        1, 1, rsp_t'{1'b1, 32'hA5A5A5A5, 5'd1});
        // fill up, then full list
        add_row(CMD_APPEND, 0,  32'h10000000, 15, 0, '0);
        add_row(CMD_APPEND, 0,  32'hDEADBEEF, 1, 1, rsp_t'{1'b0, 32'h0, 5'd16});
        add_row(CMD_READ,   15, 32'h0,        1, 0, '0);
        add_row(CMD_WRITE,  15, 32'h5A5A5A5A, 1, 0, '0);
        add_row(CMD_REMOVE, 15, 32'h0,        1, 0, '0);
        add_row(CMD_REMOVE, 0,  32'h0,        1, 0, '0);
        add_row(CMD_RSVD_C, 3,  32'h0,        1, 0, '0);
        add_row(CMD_READ,   13, 32'h0,        1, 0, '0);
        add_row(CMD_READ,   14, 32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd14});
        add_row(CMD_CLEAR,  9,  32'h0,        1, 1, rsp_t'{1'b1, 32'h0, 5'd0});
        add_row(CMD_READ,   0,  32'h0,        1, 1, rsp_t'{1'b0, 32'h0, 5'd0});

        foreach (step_rows[i])
        begin
            row = step_rows[i];
            for (rep = 0; rep < row.reps; rep++)
            begin
                r = row.req;
                r.entry_value = row.req.entry_value + rep;
                issue(r, row.typed, row.want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(99) < idle_pct[p])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                end
                issue(pick_list_request(), 0, '0);
            end
        end
        start <= 1'b0;

        n = 0;
        while (pending_results.size() != 0 && n < 100)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
